### rtl/core/ucde_pkg.sv
// Shared types, codes and helper functions of the codepoint encoder.
`default_nettype none

package ucde_pkg;

    localparam int CP_W      = 21;
    localparam int RUN_MAX   = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 3;

    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] BMP_MAX  = 21'h00FFFF;
    localparam logic [CP_W-1:0] ASCII_LIM = 21'h000080;
    localparam logic [CP_W-1:0] UTF8_LIM2 = 21'h000800;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

    // Encodings selected by target_encoding.
    localparam logic [2:0] ENC_ASCII = 3'd0;
    localparam logic [2:0] ENC_UCS2  = 3'd1;
    localparam logic [2:0] ENC_UTF8  = 3'd2;
    localparam logic [2:0] ENC_UTF16 = 3'd3;
    localparam logic [2:0] ENC_UTF32 = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_RANGE     = 2'd1;
    localparam logic [1:0] ERR_NOT_ASCII = 2'd2;
    localparam logic [1:0] ERR_NOT_BMP   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ENCODING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_BOM        = 2'd2;

    // Byte constants.
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] HI_SURR    = 8'hD8;
    localparam logic [7:0] LO_SURR    = 8'hDC;
    localparam logic [7:0] BOM8_0     = 8'hEF;
    localparam logic [7:0] BOM8_1     = 8'hBB;
    localparam logic [7:0] BOM8_2     = 8'hBF;
    localparam logic [15:0] BOM_UNIT  = 16'hFEFF;

    typedef struct packed {
        logic [2:0] target_encoding;
        logic       little_endian;
        logic       emit_bom;
    } cfg_t;

    // One item's bytes; element 0 goes out first.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic [1:0]              err;
    } run_t;

    // A 16-bit code unit in transfer order.
    function automatic logic [1:0][7:0] order16(input logic [15:0] u, input logic le);
        logic [1:0][7:0] r;
        if (le)
        begin
            r[0] = u[7:0];
            r[1] = u[15:8];
        end
        else
        begin
            r[0] = u[15:8];
            r[1] = u[7:0];
        end
        return r;
    endfunction

    // A 32-bit code unit in transfer order.
    function automatic logic [3:0][7:0] order32(input logic [31:0] u, input logic le);
        logic [3:0][7:0] r;
        if (le)
        begin
            r[0] = u[7:0];
            r[1] = u[15:8];
            r[2] = u[23:16];
            r[3] = u[31:24];
        end
        else
        begin
            r[0] = u[31:24];
            r[1] = u[23:16];
            r[2] = u[15:8];
            r[3] = u[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ucde_if.sv
// Channel interfaces: codepoint items in and encoded bytes out.
`default_nettype none

interface ucde_cp_if;
    logic                       valid;
    logic                       ready;
    logic [ucde_pkg::CP_W-1:0]  code_point;
    logic                       first_of_text;

    modport source (output valid, output code_point, output first_of_text, input ready);
    modport sink   (input valid, input code_point, input first_of_text, output ready);
endinterface

interface ucde_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output last_of_run, output error_code,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input error_code,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/ucde_encoder.sv
// Combinational encoder: one codepoint to its full byte run.
`default_nettype none

module ucde_encoder (
    input  wire logic [ucde_pkg::CP_W-1:0] code_point,
    input  wire logic                      first_of_text,
    input  wire ucde_pkg::cfg_t            cfg,
    output ucde_pkg::run_t                 run
);

    logic [3:0][7:0] data;
    logic [2:0]      data_n;
    logic [3:0][7:0] bom;
    logic [2:0]      bom_n;
    logic [1:0]      err;
    logic            known;
    logic [19:0]     supp;
    logic [1:0][7:0] u_hi;
    logic [1:0][7:0] u_lo;
    logic [3:0]      k;
    logic [ucde_pkg::CP_W-1:0] cp;

    assign cp = code_point;

    always_comb
    begin
        data   = '0;
        data_n = 3'd0;
        bom    = '0;
        bom_n  = 3'd0;
        err    = ucde_pkg::ERR_NONE;
        known  = 1'b1;
        supp   = 20'(cp - ucde_pkg::SUPP_BASE);
        u_hi   = ucde_pkg::order16({ucde_pkg::HI_SURR[7:2], supp[19:10]},
                                   cfg.little_endian);
        u_lo   = ucde_pkg::order16({ucde_pkg::LO_SURR[7:2], supp[9:0]},
                                   cfg.little_endian);

        unique case (cfg.target_encoding)
            ucde_pkg::ENC_ASCII:
            begin
                data[0] = cp[7:0];
                data_n  = 3'd1;
                if (cp >= ucde_pkg::ASCII_LIM)
                    err = ucde_pkg::ERR_NOT_ASCII;
                bom[0]  = ucde_pkg::BOM8_0;
                bom[1]  = ucde_pkg::BOM8_1;
                bom[2]  = ucde_pkg::BOM8_2;
                bom_n   = 3'd3;
            end
            ucde_pkg::ENC_UCS2:
            begin
                data[1:0] = ucde_pkg::order16(cp[15:0], cfg.little_endian);
                data_n    = 3'd2;
                if (cp > ucde_pkg::BMP_MAX)
                    err = ucde_pkg::ERR_NOT_BMP;
                bom[1:0]  = ucde_pkg::order16(ucde_pkg::BOM_UNIT, cfg.little_endian);
                bom_n     = 3'd2;
            end
            ucde_pkg::ENC_UTF8:
            begin
                if (cp < ucde_pkg::ASCII_LIM)
                begin
                    data[0] = cp[7:0];
                    data_n  = 3'd1;
                end
                else if (cp < ucde_pkg::UTF8_LIM2)
                begin
                    data[0] = ucde_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
                    data[1] = ucde_pkg::UTF8_CONT  | {2'b00, cp[5:0]};
                    data_n  = 3'd2;
                end
                else if (cp <= ucde_pkg::BMP_MAX)
                begin
                    data[0] = ucde_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
                    data[1] = ucde_pkg::UTF8_CONT  | {2'b00, cp[11:6]};
                    data[2] = ucde_pkg::UTF8_CONT  | {2'b00, cp[5:0]};
                    data_n  = 3'd3;
                end
                else
                begin
                    data[0] = ucde_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]};
                    data[1] = ucde_pkg::UTF8_CONT  | {2'b00, cp[17:12]};
                    data[2] = ucde_pkg::UTF8_CONT  | {2'b00, cp[11:6]};
                    data[3] = ucde_pkg::UTF8_CONT  | {2'b00, cp[5:0]};
                    data_n  = 3'd4;
                end
                bom[0] = ucde_pkg::BOM8_0;
                bom[1] = ucde_pkg::BOM8_1;
                bom[2] = ucde_pkg::BOM8_2;
                bom_n  = 3'd3;
            end
            ucde_pkg::ENC_UTF16:
            begin
                if (cp <= ucde_pkg::BMP_MAX)
                begin
                    data[1:0] = ucde_pkg::order16(cp[15:0], cfg.little_endian);
                    data_n    = 3'd2;
                end
                else
                begin
                    data[1:0] = u_hi;
                    data[3:2] = u_lo;
                    data_n    = 3'd4;
                end
                bom[1:0] = ucde_pkg::order16(ucde_pkg::BOM_UNIT, cfg.little_endian);
                bom_n    = 3'd2;
            end
            ucde_pkg::ENC_UTF32:
            begin
                data   = ucde_pkg::order32({11'd0, cp}, cfg.little_endian);
                data_n = 3'd4;
                bom    = ucde_pkg::order32({16'd0, ucde_pkg::BOM_UNIT}, cfg.little_endian);
                bom_n  = 3'd4;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase

        // Out-of-range codepoints win over the per-encoding checks.
        if (cp > ucde_pkg::CP_MAX)
            err = ucde_pkg::ERR_RANGE;

        if (!(cfg.emit_bom && first_of_text))
            bom_n = 3'd0;

        run.err = err;
        if (!known)
        begin
            run.bytes = '0;
            run.count = '0;
        end
        else if (err != ucde_pkg::ERR_NONE)
        begin
            run.bytes = '0;
            run.count = 4'd1;
        end
        else
        begin
            for (int i = 0; i < ucde_pkg::RUN_MAX; i++)
            begin
                k = 4'(i) - {1'b0, bom_n};
                if (4'(i) < {1'b0, bom_n})
                    run.bytes[i] = bom[2'(i)];
                else if (k < {1'b0, data_n})
                    run.bytes[i] = data[k[1:0]];
                else
                    run.bytes[i] = 8'h00;
            end
            run.count = {1'b0, bom_n} + {1'b0, data_n};
        end
        k = '0;
    end

endmodule

`default_nettype wire

### rtl/core/ucde_serializer.sv
// Run buffer that shifts one encoded byte out per transfer.
`default_nettype none

module ucde_serializer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire ucde_pkg::run_t  run,
    output logic                 free,
    ucde_byte_if.source          bytes_ch
);

    logic [ucde_pkg::RUN_MAX-1:0][7:0] bytes_reg;
    logic [ucde_pkg::RUN_MAX-1:0][7:0] bytes_next;
    logic [ucde_pkg::CNT_W-1:0]        cnt_reg;
    logic [1:0]                        err_reg;
    logic                              take;

    assign take = bytes_ch.valid && bytes_ch.ready;

    // The buffer can take a new run when empty or when its last byte leaves now.
    assign free = (cnt_reg == '0) || (take && (cnt_reg == 4'd1));

    assign bytes_ch.valid       = (cnt_reg != '0);
    assign bytes_ch.out_byte    = bytes_reg[0];
    assign bytes_ch.last_of_run = (cnt_reg == 4'd1);
    assign bytes_ch.error_code  = err_reg;

    always_comb
    begin
        if (load)
            bytes_next = run.bytes;
        else if (take)
            bytes_next = {8'h00, bytes_reg[ucde_pkg::RUN_MAX-1:1]};
        else
            bytes_next = bytes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= run.count;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        if (load)
            err_reg <= run.err;
    end

endmodule

`default_nettype wire

### rtl/core/unicode_codepoint_encoder.sv
// Top level of the Unicode codepoint encoder.
`default_nettype none

// Takes one Unicode codepoint per transfer on cp_stream and sends its bytes, one byte per
// transfer, on byte_stream in the configured encoding (ASCII, UCS-2, UTF-8, UTF-16 with
// surrogate pairs, or UTF-32), optionally preceded by a byte order mark when the item is
// flagged first_of_text. last_of_run marks the final byte of each item. Invalid items
// (beyond U+10FFFF, non-ASCII in ASCII mode, beyond the BMP in UCS-2 mode) give a single
// zero byte carrying the error code; an undefined encoding value drops the item with no
// output. Timing: an item is captured in an input register, encoded combinationally into
// a run buffer once that buffer is free, and its bytes are then offered from the buffer.
// The output side moves one byte per cycle while the receiver accepts; a run holds 1 to 4
// bytes for the codepoint plus up to 4 for a BOM. When the receiver takes every byte, items
// that yield one byte flow at one item per cycle; a new item is taken while the previous
// run is still draining. Configuration is written through cfg_we/cfg_index/cfg_data and
// should change only while the block is idle.

module unicode_codepoint_encoder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    ucde_cp_if.sink                                 cp_stream,
    ucde_byte_if.source                             byte_stream,
    input  wire logic                               cfg_we,
    input  wire logic [ucde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ucde_pkg::CFG_W-1:0]         cfg_data
);

    ucde_pkg::cfg_t              cfg_reg;
    logic [ucde_pkg::CP_W-1:0]   cp_reg;
    logic                        first_reg;
    logic                        hold_valid_reg;
    ucde_pkg::run_t              run;
    logic                        free;
    logic                        load;
    logic                        advance;

    // Configuration registers; writes to an index past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_encoding <= ucde_pkg::ENC_UTF8;
            cfg_reg.little_endian   <= 1'b0;
            cfg_reg.emit_bom        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ucde_pkg::CFG_TARGET_ENCODING: cfg_reg.target_encoding <= cfg_data;
                ucde_pkg::CFG_LITTLE_ENDIAN:   cfg_reg.little_endian   <= cfg_data[0];
                ucde_pkg::CFG_EMIT_BOM:        cfg_reg.emit_bom        <= cfg_data[0];
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // The held item leaves the input register either into the run buffer or,
    // when it produces no bytes at all, simply by being dropped.
    assign load    = hold_valid_reg && (run.count != '0) && free;
    assign advance = hold_valid_reg && ((run.count == '0) || free);

    assign cp_stream.ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (cp_stream.ready)
        begin
            hold_valid_reg <= cp_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cp_stream.valid && cp_stream.ready)
        begin
            cp_reg    <= cp_stream.code_point;
            first_reg <= cp_stream.first_of_text;
        end
    end

    ucde_encoder u_encoder (
        .code_point    (cp_reg),
        .first_of_text (first_reg),
        .cfg           (cfg_reg),
        .run           (run)
    );

    ucde_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .run      (run),
        .free     (free),
        .bytes_ch (byte_stream)
    );

endmodule

`default_nettype wire

### rtl/core/ucde_checker.sv
// Port-level assertions for the codepoint encoder and their bind.
`default_nettype none

module ucde_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run,
    input wire logic [1:0] error_code
);

    // An error result is a run of its own.
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ucde_pkg::ERR_NONE) |-> last_of_run)
        else $error("error result not marked last_of_run");

    // An error result carries a zero byte.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ucde_pkg::ERR_NONE) |-> (out_byte == 8'h00))
        else $error("error result with nonzero byte");

    // Once a run has started, its remaining bytes follow without a gap.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_run) |=> out_valid)
        else $error("gap inside a byte run");

    // A stalled byte holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)
                                       && $stable(last_of_run)))
        else $error("stalled output changed");

endmodule

bind unicode_codepoint_encoder ucde_checker u_ucde_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (byte_stream.valid),
    .out_ready   (byte_stream.ready),
    .out_byte    (byte_stream.out_byte),
    .last_of_run (byte_stream.last_of_run),
    .error_code  (byte_stream.error_code)
);

`default_nettype wire

### tb/cp_encoder_checker.sv
// Checker for the codepoint encoder: predicts the encoded bytes and compares each output transfer.
`timescale 1ns / 100ps

module cp_encoder_checker
    import ucde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ucde_cp_if                   cp_ch,
    ucde_byte_if                 byte_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   bytes_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } enc_byte_t;

    enc_byte_t  expected_bytes[$];
    logic [2:0] enc_cfg;
    logic       le_cfg;
    logic       bom_cfg;
    int         mismatches;
    int         bytes_seen;

    assign fail_count    = mismatches;
    assign bytes_checked = bytes_seen;

    initial
    begin
        mismatches = 0;
        bytes_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] ERROR %s", $time, msg);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        expected_bytes.insert(expected_bytes.size(), '{data: b, last: 1'b0, err: ERR_NONE});
    endfunction

    function automatic void put_unit16(input logic [15:0] u);
        if (le_cfg)
        begin
            put_byte(u[7:0]);
            put_byte(u[15:8]);
        end
        else
        begin
            put_byte(u[15:8]);
            put_byte(u[7:0]);
        end
    endfunction

    function automatic void put_unit32(input logic [31:0] u);
        int lane;
        for (int k = 0; k < 4; k++)
        begin
            lane = le_cfg ? k : 3 - k;
            put_byte(u[8*lane +: 8]);
        end
    endfunction

    // Appends the bytes one accepted codepoint should produce, with the final one marked.
    function automatic void encode_codepoint(input logic [CP_W-1:0] cp, input logic first);
        logic [1:0]      err;
        logic [CP_W-1:0] v;
        if (enc_cfg > ENC_UTF32)
        begin
            return;
        end
        err = ERR_NONE;
        if (cp > CP_MAX)
        begin
            err = ERR_RANGE;
        end
        else if (enc_cfg == ENC_ASCII && cp >= ASCII_LIM)
        begin
            err = ERR_NOT_ASCII;
        end
        else if (enc_cfg == ENC_UCS2 && cp > BMP_MAX)
        begin
            err = ERR_NOT_BMP;
        end
        if (err != ERR_NONE)
        begin
            expected_bytes.insert(expected_bytes.size(), '{data: 8'h00, last: 1'b1, err: err});
            return;
        end
        if (bom_cfg && first)
        begin
            if (enc_cfg == ENC_ASCII || enc_cfg == ENC_UTF8)
            begin
                put_byte(BOM8_0);
                put_byte(BOM8_1);
                put_byte(BOM8_2);
            end
            else if (enc_cfg == ENC_UTF32)
            begin
                put_unit32({16'h0000, BOM_UNIT});
            end
            else
            begin
                put_unit16(BOM_UNIT);
            end
        end
        case (enc_cfg)
            ENC_ASCII:
            begin
                put_byte(cp[7:0]);
            end
            ENC_UCS2:
            begin
                put_unit16(cp[15:0]);
            end
            ENC_UTF8:
            begin
                if (cp < ASCII_LIM)
                begin
                    put_byte(cp[7:0]);
                end
                else if (cp < UTF8_LIM2)
                begin
                    put_byte(UTF8_LEAD2 | {3'b000, cp[10:6]});
                    put_byte(UTF8_CONT | {2'b00, cp[5:0]});
                end
                else if (cp < SUPP_BASE)
                begin
                    put_byte(UTF8_LEAD3 | {4'b0000, cp[15:12]});
                    put_byte(UTF8_CONT | {2'b00, cp[11:6]});
                    put_byte(UTF8_CONT | {2'b00, cp[5:0]});
                end
                else
                begin
                    put_byte(UTF8_LEAD4 | {5'b00000, cp[20:18]});
                    put_byte(UTF8_CONT | {2'b00, cp[17:12]});
                    put_byte(UTF8_CONT | {2'b00, cp[11:6]});
                    put_byte(UTF8_CONT | {2'b00, cp[5:0]});
                end
            end
            ENC_UTF16:
            begin
                if (cp <= BMP_MAX)
                begin
                    put_unit16(cp[15:0]);
                end
                else
                begin
                    v = cp - SUPP_BASE;
                    put_unit16({HI_SURR, 8'h00} | {6'b000000, v[19:10]});
                    put_unit16({LO_SURR, 8'h00} | {6'b000000, v[9:0]});
                end
            end
            default:
            begin
                put_unit32({11'b0, cp});
            end
        endcase
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    task automatic check_byte(input logic [7:0] data, input logic last, input logic [1:0] err);
        enc_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("byte %02h arrived with nothing pending", data));
            return;
        end
        want = expected_bytes.pop_front();
        bytes_seen++;
        if (data !== want.data)
        begin
            report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
        end
        if (last !== want.last)
        begin
            report_mismatch($sformatf("last_of_run %b, want %b (byte %02h)", last, want.last,
                                      want.data));
        end
        if (err !== want.err)
        begin
            report_mismatch($sformatf("error_code %0d, want %0d", err, want.err));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_cfg = ENC_UTF8;
            le_cfg  = 1'b0;
            bom_cfg = 1'b0;
            expected_bytes.delete();
            pending <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                check_byte(byte_ch.out_byte, byte_ch.last_of_run, byte_ch.error_code);
            end
            if (cp_ch.valid && cp_ch.ready)
            begin
                encode_codepoint(cp_ch.code_point, cp_ch.first_of_text);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_ENCODING: enc_cfg = cfg_data;
                    CFG_LITTLE_ENDIAN:   le_cfg  = cfg_data[0];
                    CFG_EMIT_BOM:        bom_cfg = cfg_data[0];
                    default: ;
                endcase
            end
            pending <= expected_bytes.size();
        end
    end

endmodule

### tb/tb_top.sv
// Top of the codepoint encoder testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
    import ucde_pkg::*;

    // Cycles to let pass once nothing is pending, so that items the block drops without
    // output have also left its input register.
    localparam int DRAIN_CYCLES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int bytes_checked;

    // Sender bookkeeping. burst_left counts transfers left in the current burst; no_gaps
    // forces back-to-back offers while the receiver is held off.
    int   burst_left    = 0;
    bit   no_gaps       = 1'b0;
    int   items_sent    = 0;
    int   settings_used = 1;
    logic hold_request  = 1'b0;

    ucde_cp_if   cp_ch ();
    ucde_byte_if byte_ch ();

    unicode_codepoint_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cp_stream   (cp_ch),
        .byte_stream (byte_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    cp_encoder_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cp_ch         (cp_ch),
        .byte_ch       (byte_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The slowest correct run stays well within this limit even with every item giving eight
    // bytes into the heaviest stall pattern.
    initial
    begin
        #1ms;
        $display("Timeout with %0d bytes still pending", pending);
        $display("unicode_codepoint_encoder test failed");
        $finish;
    end

    // Receiver. The stall rate changes from window to window, from no stalls at all to
    // mostly stalled, so gaps land on every byte position of a run. A hold request from
    // the stimulus makes it refuse every transfer for a long stretch, counted here.
    initial
    begin
        int window;
        int stall_pct;
        int hold_left;
        window    = 0;
        stall_pct = 0;
        hold_left = 0;
        byte_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                window = $urandom_range(48, 16);
                case ($urandom_range(4, 0))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            window--;
            if (hold_request && hold_left == 0)
            begin
                hold_left = $urandom_range(90, 70);
                hold_request <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end
            else
            begin
                byte_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // Offers one codepoint and returns right after its transfer. Items go out in bursts of
    // random length; between bursts valid may drop for a random gap. valid is
    // only lowered when a gap actually follows, so it never gets two updates in one step.
    task automatic send_cp(input logic [CP_W-1:0] cp, input logic first);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(12, 1);
            gap = no_gaps ? 0 : $urandom_range(6, 0);
            if (gap > 0)
            begin
                cp_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        cp_ch.valid         <= 1'b1;
        cp_ch.code_point    <= cp;
        cp_ch.first_of_text <= first;
        do
            @(posedge clk);
        while (!cp_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    // Stops offering and waits until every predicted byte has arrived, then DRAIN_CYCLES more
    // so that items without output have also left the block.
    task automatic wait_drained;
        cp_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Registers only change while the block is idle. cfg_we stays high across the three
    // writes and drops once after the last one.
    task automatic set_config(input logic [2:0] enc, input logic le, input logic bom);
        wait_drained();
        write_reg(CFG_TARGET_ENCODING, enc);
        write_reg(CFG_LITTLE_ENDIAN, {2'b00, le});
        write_reg(CFG_EMIT_BOM, {2'b00, bom});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Spreads codepoints over every UTF-8 length class, the surrogate block, the
    // supplementary planes and the out-of-range values. ASCII mode gets mostly 7-bit values
    // so that its good path is not drowned in errors.
    function automatic logic [CP_W-1:0] pick_codepoint(input logic [2:0] enc);
        int unsigned sel;
        logic [31:0] r;
        sel = $urandom_range(99, 0);
        if (enc == ENC_ASCII && sel < 60)
        begin
            r = $urandom_range(32'h7F, 0);
        end
        else if (sel < 20)
        begin
            r = $urandom_range(32'h7F, 0);
        end
        else if (sel < 40)
        begin
            r = $urandom_range(32'h7FF, 32'h80);
        end
        else if (sel < 58)
        begin
            r = $urandom_range(32'hFFFF, 32'h800);
        end
        else if (sel < 68)
        begin
            r = $urandom_range(32'hDFFF, 32'hD800);
        end
        else if (sel < 88)
        begin
            r = $urandom_range(32'h10FFFF, 32'h10000);
        end
        else
        begin
            r = $urandom_range(32'h1FFFFF, 32'h110000);
        end
        return r[CP_W-1:0];
    endfunction

    initial
    begin
        int          directed_items;
        int          n_items;
        logic [2:0]  enc;
        logic        le;
        logic        bom;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_TARGET_ENCODING;
        cfg_data            <= '0;
        cp_ch.valid         <= 1'b0;
        cp_ch.code_point    <= '0;
        cp_ch.first_of_text <= 1'b0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset settings are UTF-8, big-endian, no BOM: walk every UTF-8
        // length boundary and both sides of the top of the code space.
        send_cp(21'h000000, 1'b1);
        send_cp(21'h00007F, 1'b0);
        send_cp(21'h000080, 1'b0);
        send_cp(21'h0007FF, 1'b0);
        send_cp(21'h000800, 1'b0);
        send_cp(21'h00FFFF, 1'b0);
        send_cp(21'h010000, 1'b0);
        send_cp(21'h10FFFF, 1'b0);
        send_cp(21'h110000, 1'b1);
        send_cp(21'h1FFFFF, 1'b0);

        // ASCII with the three-byte mark; a non-ASCII item flagged first gets no mark.
        set_config(ENC_ASCII, 1'b0, 1'b1);
        send_cp(21'h000041, 1'b1);
        send_cp(21'h000080, 1'b1);
        send_cp(21'h00007F, 1'b0);

        // UTF-16 little-endian with a mark: a surrogate pair, a lone surrogate value taken
        // as an ordinary unit, and the highest codepoint.
        set_config(ENC_UTF16, 1'b1, 1'b1);
        send_cp(21'h01F600, 1'b1);
        send_cp(21'h00D800, 1'b0);
        send_cp(21'h10FFFF, 1'b0);

        // UCS-2 big-endian: the top of the BMP with a mark, then one past it.
        set_config(ENC_UCS2, 1'b0, 1'b1);
        send_cp(21'h00FFFF, 1'b1);
        send_cp(21'h010000, 1'b1);

        // UTF-32 in both byte orders, each with a mark; out of range still wins.
        set_config(ENC_UTF32, 1'b1, 1'b1);
        send_cp(21'h10FFFF, 1'b1);
        send_cp(21'h1FFFFF, 1'b1);
        set_config(ENC_UTF32, 1'b0, 1'b1);
        send_cp(21'h012345, 1'b1);

        // Undefined encoding values drop the item; both ends of that range.
        set_config(3'd5, 1'b0, 1'b0);
        send_cp(21'h000041, 1'b1);
        set_config(3'd7, 1'b1, 1'b1);
        send_cp(21'h10FFFF, 1'b0);
        directed_items = items_sent;

        // Random part. The first five phases visit every encoding, and the byte order and
        // mark settings rotate; later phases pick freely. Two phases hold the receiver off
        // while items keep coming back to back, so the block fills and stops taking input.
        for (int p = 0; p < 8; p++)
        begin
            enc = (p < 5) ? p[2:0] : 3'($urandom_range(4, 0));
            le  = p[0];
            bom = p[1] | (p >= 5);
            set_config(enc, le, bom);
            n_items = 12;
            if (p == 2 || p == 6)
            begin
                hold_request <= 1'b1;
                no_gaps = 1'b1;
                n_items = 16;
            end
            for (int i = 0; i < n_items; i++)
            begin
                send_cp(pick_codepoint(enc), (i == 0) || ($urandom_range(3, 0) == 0));
            end
            no_gaps = 1'b0;
        end

        wait_drained();

        $display("Sent %0d codepoints (%0d directed) across %0d encoder settings,",
                 items_sent, directed_items, settings_used);
        $display("checked %0d output bytes with %0d mismatches.", bytes_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("unicode_codepoint_encoder test passed");
        end
        else
        begin
            $display("unicode_codepoint_encoder test failed");
        end
        $finish;
    end

endmodule

### unicode_codepoint_encoder.f
rtl/core/ucde_pkg.sv
rtl/core/ucde_if.sv
rtl/core/ucde_encoder.sv
rtl/core/ucde_serializer.sv
rtl/core/unicode_codepoint_encoder.sv
rtl/core/ucde_checker.sv
tb/cp_encoder_checker.sv
tb/tb_top.sv
